@@ hdl/pst_pkg.sv @@
// pst_pkg: shared constants and types for the propensity sum tree sampler.
// Used by pst_mul, pst_tree and propensity_sum_tree_sampler.
`default_nettype none

package pst_pkg;

    localparam int REACTIONS              = 256;
    localparam int MAX_ORDER              = 3;
    localparam int REACTANTS_PER_REACTION = 2;

    localparam int IDX_W   = $clog2(REACTIONS);
    localparam int CHILD_W = IDX_W + 2;
    localparam int SEL_W   = 8;
    localparam int RIDX_W  = 8;
    localparam int RATE_W  = 32;
    localparam int CNT_W   = 16;
    localparam int ORDER_W = 2;
    localparam int FRAC_W  = 32;
    localparam int PROP_W  = 48;
    localparam int SUM_W   = 56;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;

    localparam logic [PROP_W-1:0] PROP_MAX = '1;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [SUM_W-1:0]  right_sum;
        logic [SUM_W-1:0]  left_sum;
        logic [PROP_W-1:0] own;
    } node_t;

    typedef struct packed {
        logic  rd_en;
        idx_t  rd_addr;
        logic  wr_en;
        idx_t  wr_addr;
        node_t wr_data;
    } tree_req_t;

    typedef struct packed {
        logic [MUL_W-1:0]  a;
        logic [MUL_W-1:0]  b;
        logic              shift_hi;
        logic [PROD_W-1:0] addend;
    } mul_req_t;

endpackage

`default_nettype wire

@@ hdl/pst_mul.sv @@
// pst_mul: shared 32x32 multiply-accumulate used for partial products.
// Depends on pst_pkg.
`default_nettype none

module pst_mul (
    input  wire pst_pkg::mul_req_t        req,
    output logic [pst_pkg::PROD_W-1:0]    result
);

    logic [pst_pkg::PROD_W-1:0] product;
    logic [pst_pkg::PROD_W-1:0] shifted;

    always_comb begin
        product = pst_pkg::PROD_W'(req.a) * pst_pkg::PROD_W'(req.b);
        if (req.shift_hi) begin
            shifted = {product[pst_pkg::MUL_W-1:0], {pst_pkg::MUL_W{1'b0}}};
        end else begin
            shifted = product;
        end
        result = shifted + req.addend;
    end

endmodule

`default_nettype wire

@@ hdl/pst_tree.sv @@
// pst_tree: heap node store (own propensity, left and right subtree sums).
// One read and one write port, registered read, per-entry valid bits.
// Depends on pst_pkg.
`default_nettype none

module pst_tree (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire pst_pkg::tree_req_t req,
    output pst_pkg::node_t         rd_data
);

    pst_pkg::node_t                 mem [pst_pkg::REACTIONS];
    logic [pst_pkg::REACTIONS-1:0]  valid_reg;
    pst_pkg::node_t                 rd_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_reg : '0;

    a_no_same_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        req.rd_en && req.wr_en |-> req.rd_addr != req.wr_addr)
        else $error("tree read and write hit the same node");

endmodule

`default_nettype wire

@@ hdl/propensity_sum_tree_sampler.sv @@
// Update: rate times each count's falling factorial via pst_mul, low then high half, then
// node read and write and the parent sums up to the root; a count below its order gives zero
// and skips the product. Search: total times fraction, then a walk down from the root, which
// a zero total skips. One item at a time, all tree traffic through one node RAM port pair.
// Synchronous active-low reset clears the node valid bits and the total at once, no sweep.
// Sequencer with pst_mul and pst_tree; depends on pst_pkg.
`default_nettype none

module propensity_sum_tree_sampler (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // [7:0] reaction_index, [39:8] rate, [55:40] first_count, [57:56] first_order,
    // [73:58] second_count, [75:74] second_order, [107:76] random_fraction, [111:108] zero
    input  wire  [111:0] s_tdata,
    // [0] kind
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // [7:0] selected_index, [63:8] total_propensity, [111:64] node_propensity
    output logic [111:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PR_LO,
        ST_PR_HI,
        ST_NODE_RD,
        ST_NODE_WR,
        ST_UP_WR,
        ST_SC_LO,
        ST_SC_HI,
        ST_WALK_L,
        ST_WALK_OWN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [pst_pkg::PROP_W-1:0]  acc_reg, acc_next;
    logic [pst_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [pst_pkg::ORDER_W-1:0] rem_reg, rem_next;
    logic [pst_pkg::CNT_W-1:0]   cnt2_reg, cnt2_next;
    logic [pst_pkg::ORDER_W-1:0] rem2_reg, rem2_next;
    logic [pst_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [pst_pkg::FRAC_W-1:0]  frac_reg, frac_next;
    logic [pst_pkg::SUM_W-1:0]   target_reg, target_next;
    logic [pst_pkg::SUM_W-1:0]   delta_reg, delta_next;
    logic [pst_pkg::SUM_W-1:0]   total_reg, total_next;
    pst_pkg::idx_t               node_reg, node_next;
    logic                        odd_reg, odd_next;
    logic [pst_pkg::SEL_W-1:0]   sel_reg, sel_next;
    logic [pst_pkg::PROP_W-1:0]  written_reg, written_next;
    logic                        m_valid_reg, m_valid_next;
    logic [pst_pkg::SEL_W-1:0]   m_sel_reg, m_sel_next;
    logic [pst_pkg::SUM_W-1:0]   m_total_reg, m_total_next;
    logic [pst_pkg::PROP_W-1:0]  m_prop_reg, m_prop_next;

    pst_pkg::mul_req_t           mreq;
    logic [pst_pkg::PROD_W-1:0]  mres;
    pst_pkg::tree_req_t          treq;
    pst_pkg::node_t              rd;

    logic [pst_pkg::RIDX_W-1:0]  in_idx;
    logic [pst_pkg::RATE_W-1:0]  in_rate;
    logic [pst_pkg::CNT_W-1:0]   in_c0, in_c1;
    logic [pst_pkg::ORDER_W-1:0] in_k0, in_k1, k0c, k1c;
    logic [pst_pkg::FRAC_W-1:0]  in_frac;

    logic [pst_pkg::SUM_W-1:0]   left_diff, own_diff;
    logic [pst_pkg::CHILD_W-1:0] child_l, child_r;
    pst_pkg::idx_t               parent;

    pst_mul u_mul (
        .req    (mreq),
        .result (mres)
    );

    pst_tree u_tree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (treq),
        .rd_data (rd)
    );

    assign in_idx  = s_tdata[7:0];
    assign in_rate = s_tdata[39:8];
    assign in_c0   = s_tdata[55:40];
    assign in_k0   = s_tdata[57:56];
    assign in_c1   = s_tdata[73:58];
    assign in_k1   = s_tdata[75:74];
    assign in_frac = s_tdata[107:76];

    always_comb begin
        k0c = (32'(in_k0) > pst_pkg::MAX_ORDER) ? pst_pkg::ORDER_W'(pst_pkg::MAX_ORDER) : in_k0;
        k1c = (32'(in_k1) > pst_pkg::MAX_ORDER) ? pst_pkg::ORDER_W'(pst_pkg::MAX_ORDER) : in_k1;
        if (pst_pkg::REACTANTS_PER_REACTION < 2) begin
            k1c = '0;
        end
    end

    assign left_diff = target_reg - rd.left_sum;
    assign own_diff  = target_reg - pst_pkg::SUM_W'(rd.own);
    assign child_l   = {1'b0, node_reg, 1'b1};
    assign child_r   = {1'b0, node_reg, 1'b0} + pst_pkg::CHILD_W'(2);
    assign parent    = pst_pkg::IDX_W'((node_reg - 1'b1) >> 1);

    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        cnt2_next    = cnt2_reg;
        rem2_next    = rem2_reg;
        prod_next    = prod_reg;
        frac_next    = frac_reg;
        target_next  = target_reg;
        delta_next   = delta_reg;
        total_next   = total_reg;
        node_next    = node_reg;
        odd_next     = odd_reg;
        sel_next     = sel_reg;
        written_next = written_reg;
        m_valid_next = m_valid_reg;
        m_sel_next   = m_sel_reg;
        m_total_next = m_total_reg;
        m_prop_next  = m_prop_reg;
        mreq         = '0;
        treq         = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sel_next     = '0;
                    written_next = '0;
                    frac_next    = in_frac;
                    node_next    = pst_pkg::IDX_W'(in_idx);
                    acc_next     = pst_pkg::PROP_W'(in_rate);
                    cnt_next     = in_c0;
                    rem_next     = k0c;
                    cnt2_next    = in_c1;
                    rem2_next    = k1c;
                    if (s_tuser[0] == pst_pkg::KIND_SEARCH) begin
                        state_next = (total_reg == '0) ? ST_DONE : ST_SC_LO;
                    end else if ({1'b0, in_idx} >= (pst_pkg::RIDX_W + 1)'(pst_pkg::REACTIONS)) begin
                        state_next = ST_DONE;
                    end else if (in_c0 < pst_pkg::CNT_W'(k0c) || in_c1 < pst_pkg::CNT_W'(k1c)) begin
                        acc_next   = '0;
                        state_next = ST_NODE_RD;
                    end else begin
                        state_next = ST_PR_LO;
                    end
                end
            end
            ST_PR_LO: begin
                if (rem_reg == '0) begin
                    if (rem2_reg != '0) begin
                        cnt_next  = cnt2_reg;
                        rem_next  = rem2_reg;
                        rem2_next = '0;
                    end else begin
                        state_next = ST_NODE_RD;
                    end
                end else begin
                    mreq.a     = acc_reg[pst_pkg::MUL_W-1:0];
                    mreq.b     = pst_pkg::MUL_W'(cnt_reg);
                    prod_next  = mres;
                    state_next = ST_PR_HI;
                end
            end
            ST_PR_HI: begin
                mreq.a        = pst_pkg::MUL_W'(acc_reg[pst_pkg::PROP_W-1:pst_pkg::MUL_W]);
                mreq.b        = pst_pkg::MUL_W'(cnt_reg);
                mreq.shift_hi = 1'b1;
                mreq.addend   = prod_reg;
                if (mres[pst_pkg::PROD_W-1:pst_pkg::PROP_W] != '0) begin
                    acc_next = pst_pkg::PROP_MAX;
                end else begin
                    acc_next = mres[pst_pkg::PROP_W-1:0];
                end
                cnt_next   = cnt_reg - 1'b1;
                rem_next   = rem_reg - 1'b1;
                state_next = ST_PR_LO;
            end
            ST_NODE_RD: begin
                treq.rd_en   = 1'b1;
                treq.rd_addr = node_reg;
                state_next   = ST_NODE_WR;
            end
            ST_NODE_WR: begin
                delta_next    = pst_pkg::SUM_W'(acc_reg) - pst_pkg::SUM_W'(rd.own);
                total_next    = total_reg + pst_pkg::SUM_W'(acc_reg) - pst_pkg::SUM_W'(rd.own);
                written_next  = acc_reg;
                treq.wr_en    = 1'b1;
                treq.wr_addr  = node_reg;
                treq.wr_data  = rd;
                treq.wr_data.own = acc_reg;
                if (node_reg != '0) begin
                    treq.rd_en   = 1'b1;
                    treq.rd_addr = parent;
                    odd_next     = node_reg[0];
                    node_next    = parent;
                    state_next   = ST_UP_WR;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_UP_WR: begin
                treq.wr_en   = 1'b1;
                treq.wr_addr = node_reg;
                treq.wr_data = rd;
                if (odd_reg) begin
                    treq.wr_data.left_sum = rd.left_sum + delta_reg;
                end else begin
                    treq.wr_data.right_sum = rd.right_sum + delta_reg;
                end
                if (node_reg != '0) begin
                    treq.rd_en   = 1'b1;
                    treq.rd_addr = parent;
                    odd_next     = node_reg[0];
                    node_next    = parent;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SC_LO: begin
                mreq.a     = total_reg[pst_pkg::MUL_W-1:0];
                mreq.b     = frac_reg;
                prod_next  = mres;
                state_next = ST_SC_HI;
            end
            ST_SC_HI: begin
                mreq.a       = pst_pkg::MUL_W'(total_reg[pst_pkg::SUM_W-1:pst_pkg::MUL_W]);
                mreq.b       = frac_reg;
                mreq.addend  = pst_pkg::PROD_W'(prod_reg[pst_pkg::PROD_W-1:pst_pkg::MUL_W]);
                target_next  = mres[pst_pkg::SUM_W-1:0];
                node_next    = '0;
                treq.rd_en   = 1'b1;
                treq.rd_addr = '0;
                state_next   = ST_WALK_L;
            end
            ST_WALK_L: begin
                if (target_reg < rd.left_sum) begin
                    if (child_l >= pst_pkg::CHILD_W'(pst_pkg::REACTIONS)) begin
                        sel_next   = pst_pkg::SEL_W'(node_reg);
                        state_next = ST_DONE;
                    end else begin
                        treq.rd_en   = 1'b1;
                        treq.rd_addr = pst_pkg::IDX_W'(child_l);
                        node_next    = pst_pkg::IDX_W'(child_l);
                    end
                end else begin
                    target_next = left_diff;
                    state_next  = ST_WALK_OWN;
                end
            end
            ST_WALK_OWN: begin
                if (target_reg < pst_pkg::SUM_W'(rd.own)) begin
                    sel_next   = pst_pkg::SEL_W'(node_reg);
                    state_next = ST_DONE;
                end else begin
                    target_next = own_diff;
                    if (child_r >= pst_pkg::CHILD_W'(pst_pkg::REACTIONS)) begin
                        sel_next   = pst_pkg::SEL_W'(node_reg);
                        state_next = ST_DONE;
                    end else begin
                        treq.rd_en   = 1'b1;
                        treq.rd_addr = pst_pkg::IDX_W'(child_r);
                        node_next    = pst_pkg::IDX_W'(child_r);
                        state_next   = ST_WALK_L;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sel_next   = sel_reg;
                    m_total_next = total_reg;
                    m_prop_next  = written_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        cnt2_reg    <= cnt2_next;
        rem2_reg    <= rem2_next;
        prod_reg    <= prod_next;
        frac_reg    <= frac_next;
        target_reg  <= target_next;
        delta_reg   <= delta_next;
        node_reg    <= node_next;
        odd_reg     <= odd_next;
        sel_reg     <= sel_next;
        written_reg <= written_next;
        m_sel_reg   <= m_sel_next;
        m_total_reg <= m_total_next;
        m_prop_reg  <= m_prop_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_prop_reg, m_total_reg, m_sel_reg};

    a_idle_no_tree: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !treq.rd_en && !treq.wr_en)
        else $error("tree access while idle");

    a_multi_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready again right after a transfer");

    a_zero_total_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63:8] == '0 |-> m_tdata[7:0] == '0)
        else $error("nonzero selection with zero total");

endmodule

`default_nettype wire

@@ tb/sv/propensity_sum_tree_sampler_test.sv @@
// Self-checking testbench for propensity_sum_tree_sampler: directed table, then random
// update/search transfers, checked against a local sum tree predictor. Depends on pst_pkg.
module propensity_sum_tree_sampler_test;
    import pst_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [RIDX_W-1:0] idx;
        logic [RATE_W-1:0] rate;
        logic [CNT_W-1:0]  c0;
        logic [1:0]        k0;
        logic [CNT_W-1:0]  c1;
        logic [1:0]        k1;
        logic [FRAC_W-1:0] frac;
    } reaction_req_t;

    typedef struct packed {
        logic [SEL_W-1:0]  sel;
        logic [SUM_W-1:0]  total;
        logic [PROP_W-1:0] node;
    } sample_t;

    typedef struct packed {
        reaction_req_t req;
        logic          known;
        sample_t       want;
    } dir_row_t;

    localparam int RANDOM_ITEMS = 1330;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;

    logic [PROP_W-1:0] own_prop [REACTIONS];
    logic [SUM_W-1:0]  left_sum [REACTIONS];
    logic [SUM_W-1:0]  right_sum [REACTIONS];

    sample_t  pending_samples[$];
    dir_row_t dir_rows[$];
    int       mismatch_count = 0;

    propensity_sum_tree_sampler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [SUM_W-1:0] tree_total();
        return own_prop[0] + left_sum[0] + right_sum[0];
    endfunction

    function automatic logic [63:0] scale_falling(logic [63:0] acc, logic [CNT_W-1:0] cnt,
                                                  int order);
        logic [63:0] v;
        v = acc;
        for (int i = 0; i < order; i++) begin
            v = v * (64'(cnt) - 64'(i));
            if (v > 64'(PROP_MAX)) v = 64'(PROP_MAX);
        end
        return v;
    endfunction

    function automatic logic [PROP_W-1:0] propensity_of(reaction_req_t r);
        int          k0;
        int          k1;
        logic [63:0] acc;
        k0 = (int'(r.k0) > MAX_ORDER) ? MAX_ORDER : int'(r.k0);
        k1 = (int'(r.k1) > MAX_ORDER) ? MAX_ORDER : int'(r.k1);
        if (REACTANTS_PER_REACTION < 2) k1 = 0;
        if (int'(r.c0) < k0 || int'(r.c1) < k1) return '0;
        acc = scale_falling(64'(r.rate), r.c0, k0);
        acc = scale_falling(acc, r.c1, k1);
        return acc[PROP_W-1:0];
    endfunction

    function automatic logic [SEL_W-1:0] search_pick(logic [FRAC_W-1:0] frac);
        logic [SUM_W-1:0] total;
        logic [63:0]      target;
        int               n;
        int               child;
        total = tree_total();
        if (total == '0) return '0;
        target = 64'(total[SUM_W-1:32]) * 64'(frac) + ((64'(total[31:0]) * 64'(frac)) >> 32);
        n = 0;
        while (n < REACTIONS) begin
            if (target < 64'(left_sum[n])) begin
                child = 2 * n + 1;
            end else begin
                target = target - 64'(left_sum[n]);
                if (target < 64'(own_prop[n])) return SEL_W'(n);
                target = target - 64'(own_prop[n]);
                child = 2 * n + 2;
            end
            if (child >= REACTIONS) return SEL_W'(n);
            n = child;
        end
        return '0;
    endfunction

    function automatic sample_t predict_sample(reaction_req_t r);
        sample_t           s;
        logic [PROP_W-1:0] fresh;
        logic [SUM_W-1:0]  delta;
        int                n;
        int                p;
        s = '0;
        if (r.kind == KIND_UPDATE) begin
            if (int'(r.idx) < REACTIONS) begin
                fresh = propensity_of(r);
                delta = SUM_W'(fresh) - SUM_W'(own_prop[r.idx]);
                own_prop[r.idx] = fresh;
                s.node = fresh;
                n = int'(r.idx);
                while (n != 0) begin
                    p = (n - 1) >> 1;
                    if (n % 2 == 1) left_sum[p] = left_sum[p] + delta;
                    else right_sum[p] = right_sum[p] + delta;
                    n = p;
                end
            end
        end else begin
            s.sel = search_pick(r.frac);
        end
        s.total = tree_total();
        return s;
    endfunction

    function automatic reaction_req_t mk(logic kind, logic [7:0] idx, logic [31:0] rate,
                                         logic [15:0] c0, logic [1:0] k0, logic [15:0] c1,
                                         logic [1:0] k1, logic [31:0] frac);
        reaction_req_t r;
        r.kind = kind;
        r.idx  = idx;
        r.rate = rate;
        r.c0   = c0;
        r.k0   = k0;
        r.c1   = c1;
        r.k1   = k1;
        r.frac = frac;
        return r;
    endfunction

    function automatic void add_row(reaction_req_t r, logic known, logic [SEL_W-1:0] sel,
                                    logic [SUM_W-1:0] total, logic [PROP_W-1:0] node);
        dir_row_t row;
        row.req   = r;
        row.known = known;
        row.want  = '{sel: sel, total: total, node: node};
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    function automatic logic [CNT_W-1:0] random_count();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 55) return CNT_W'($urandom_range(0, 40));
        if (pick < 70) return CNT_W'($urandom_range(0, 3));
        return CNT_W'($urandom);
    endfunction

    function automatic reaction_req_t random_req();
        reaction_req_t r;
        int            pick;
        r.kind = ($urandom_range(0, 99) < 40) ? KIND_SEARCH : KIND_UPDATE;
        r.idx  = RIDX_W'($urandom);
        pick   = int'($urandom_range(0, 99));
        if (pick < 50) r.rate = RATE_W'($urandom_range(0, 32'h0004_0000));
        else if (pick < 85) r.rate = RATE_W'($urandom);
        else if (pick < 92) r.rate = '0;
        else r.rate = '1;
        r.c0   = random_count();
        r.k0   = 2'($urandom_range(0, 3));
        r.c1   = random_count();
        r.k1   = 2'($urandom_range(0, 3));
        r.frac = FRAC_W'($urandom);
        return r;
    endfunction

    task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(logic [111:0] data);
        sample_t want;
        if (pending_samples.size() == 0) begin
            flag_error("unexpected result", data[63:0], '0);
        end else begin
            want = pending_samples.pop_front();
            if (data[7:0] != want.sel)
                flag_error("selected_index", 64'(data[7:0]), 64'(want.sel));
            if (data[63:8] != want.total)
                flag_error("total_propensity", 64'(data[63:8]), 64'(want.total));
            if (data[111:64] != want.node)
                flag_error("node_propensity", 64'(data[111:64]), 64'(want.node));
        end
    endtask

    // called just after a rising edge; returns at the accepting edge, or after the idle gap if one is drawn
    task automatic send_transfer(reaction_req_t r, logic known, sample_t want, logic quiet);
        sample_t predicted;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.frac, r.k1, r.c1, r.k0, r.c0, r.rate, r.idx};
        s_tuser  <= r.kind;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_sample(r);
        pending_samples.insert(pending_samples.size(), known ? want : predicted);
        gap = (!quiet && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin : result_sink
        int seen;
        int hold_left;
        int gap_left;
        int cyc;
        seen = 0;
        hold_left = 0;
        gap_left = 0;
        cyc = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                seen++;
                if (seen == 100 || seen == 900) hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else if ((cyc / 500) % 3 != 0 && $urandom_range(0, 99) < 25) begin
                gap_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int      wait_cycles;
        sample_t none;
        none = '0;
        for (int i = 0; i < REACTIONS; i++) begin
            own_prop[i]  = '0;
            left_sum[i]  = '0;
            right_sum[i] = '0;
        end

        // empty tree, then saturation, short reactants, equal count/order, pattern values
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'h0), 1, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 8'hff, '1, '1, 3, '1, 3, 32'hffff_ffff), 1, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 0, 32'h0001_0000, 0, 0, 0, 0, 0), 1, 0, 56'h1_0000, 48'h1_0000);
        add_row(mk(KIND_UPDATE, 8'hff, '1, '1, 3, '1, 3, 0), 1,
                0, 56'h1_0000 + SUM_W'(PROP_MAX), PROP_MAX);
        add_row(mk(KIND_UPDATE, 5, 32'h0001_0000, 1, 2, 0, 0, 0), 1,
                0, 56'h1_0000 + SUM_W'(PROP_MAX), 0);
        add_row(mk(KIND_UPDATE, 8'hff, '1, '1, 3, 2, 3, 0), 1, 0, 56'h1_0000, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'h0), 1, 0, 56'h1_0000, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'hffff_ffff), 1, 0, 56'h1_0000, 0);
        add_row(mk(KIND_UPDATE, 128, 32'h0002_0000, 3, 1, 4, 2, 0), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 1, 32'h0000_8000, '1, 1, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 2, 32'h1, 10, 3, 10, 3, 0), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 254, 32'h0003_0000, 2, 2, 3, 3, 0), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 127, '1, 1, 1, 1, 1, 0), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'h0000_0001), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'h4000_0000), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'h8000_0000), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'hc000_0000), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'hffff_ffff), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 0, 0, '1, 3, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 200, 32'haaaa_5555, 16'h5555, 2, 16'haaaa, 1, 0), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 8'h55, 0, 0, 0, 0, 0, 32'h5555_5555), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 8'haa, 0, 0, 0, 0, 0, 32'haaaa_aaaa), 0, 0, 0, 0);
        add_row(mk(KIND_UPDATE, 128, 0, 0, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(KIND_SEARCH, 0, 0, 0, 0, 0, 0, 32'h1234_5678), 0, 0, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_transfer(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 700) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_samples.size() != 0);
            end
            send_transfer(random_req(), 1'b0, none, (i % 300) < 60);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending_samples.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (pending_samples.size() != 0)
            flag_error("results missing", 64'(pending_samples.size()), '0);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/pst_pkg.sv
hdl/pst_mul.sv
hdl/pst_tree.sv
hdl/propensity_sum_tree_sampler.sv
tb/sv/propensity_sum_tree_sampler_test.sv
